// ===== hw/rtl/rcb_pkg.sv =====
// rcb_pkg: shared types and constants for the cpu run-control / breakpoint block
// operation codes, request and result items, table lookup status
// no dependencies
package rcb_pkg;

    localparam int BP_SLOTS = 16;
    localparam logic [7:0] RTS_OPCODE = 8'h60;

    typedef enum logic [3:0] {
        OP_CHECK        = 4'd0,
        OP_TOGGLE_PAUSE = 4'd1,
        OP_RESUME       = 4'd2,
        OP_STEP         = 4'd3,
        OP_STEP_OVER    = 4'd4,
        OP_RUN_FREE     = 4'd5,
        OP_RUN_TO_RET   = 4'd6,
        OP_PAUSE        = 4'd7,
        OP_TOGGLE_BP    = 4'd8,
        OP_ADD_BP       = 4'd9,
        OP_REMOVE_BP    = 4'd10,
        OP_ENABLE_BP    = 4'd11,
        OP_CLEAR_BPS    = 4'd12,
        OP_QUERY_BP     = 4'd13
    } rcb_op_t;

    typedef enum logic [1:0] {
        MODE_FREE = 2'd0,
        MODE_STEP = 2'd1,
        MODE_RTR  = 2'd2
    } rcb_mode_t;

    typedef struct packed {
        logic [3:0]  operation;
        logic [15:0] address;
        logic [7:0]  opcode;
        logic        enable;
    } rcb_req_t;

    typedef struct packed {
        logic       pause_cpu;
        logic       breakpoint_active;
        logic [1:0] run_mode;
        logic       table_full;
    } rcb_result_t;

    // status of the breakpoint table for the item under work
    typedef struct packed {
        logic active;
        logic full;
    } rcb_lookup_t;

endpackage

// ===== hw/rtl/rcb_bp_table.sv =====
// rcb_bp_table: breakpoint slot table with parallel address compare
// add / remove / toggle / enable / clear, plus enabled-hit lookup
// depends on rcb_pkg
module rcb_bp_table #(
    parameter int SLOTS = rcb_pkg::BP_SLOTS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                valid,
    input  rcb_pkg::rcb_req_t   req,
    output rcb_pkg::rcb_lookup_t lookup
);
    import rcb_pkg::*;

    logic [SLOTS-1:0] used_reg;
    logic [SLOTS-1:0] used_next;
    logic [SLOTS-1:0] enabled_reg;
    logic [SLOTS-1:0] enabled_next;
    logic [15:0]      addr_reg [SLOTS];
    logic [15:0]      addr_next [SLOTS];

    logic [SLOTS-1:0] match;
    logic [SLOTS-1:0] free;
    logic [SLOTS-1:0] first_free;
    logic             hit;
    logic             want_insert;
    logic             do_insert;
    logic             do_free;

    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            match[i] = used_reg[i] && (addr_reg[i] == req.address);
        end
        hit        = |match;
        free       = ~used_reg;
        // isolate lowest free slot
        first_free = free & (~free + SLOTS'(1));

        want_insert = !hit && (req.operation == OP_TOGGLE_BP || req.operation == OP_ADD_BP);
        do_insert   = valid && want_insert && (|free);
        do_free     = valid && hit
                      && (req.operation == OP_TOGGLE_BP || req.operation == OP_REMOVE_BP);

        lookup.active = |(match & enabled_reg);
        lookup.full   = want_insert && !(|free);
    end

    always_comb
    begin
        used_next    = used_reg;
        enabled_next = enabled_reg;
        for (int i = 0; i < SLOTS; i++)
        begin
            addr_next[i] = addr_reg[i];
        end

        if (do_insert)
        begin
            used_next    = used_reg | first_free;
            enabled_next = enabled_reg | first_free;
            for (int i = 0; i < SLOTS; i++)
            begin
                if (first_free[i])
                begin
                    addr_next[i] = req.address;
                end
            end
        end
        else if (do_free)
        begin
            used_next    = used_reg & ~match;
            enabled_next = enabled_reg & ~match;
            for (int i = 0; i < SLOTS; i++)
            begin
                if (match[i])
                begin
                    addr_next[i] = '0;
                end
            end
        end
        else if (valid && req.operation == OP_ENABLE_BP)
        begin
            enabled_next = (enabled_reg & ~match) | (match & {SLOTS{req.enable}});
        end
        else if (valid && req.operation == OP_CLEAR_BPS)
        begin
            used_next    = '0;
            enabled_next = '0;
            for (int i = 0; i < SLOTS; i++)
            begin
                addr_next[i] = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg    <= '0;
            enabled_reg <= '0;
        end
        else
        begin
            used_reg    <= used_next;
            enabled_reg <= enabled_next;
        end
    end

    // addresses only matter behind a used bit
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            addr_reg[i] <= addr_next[i];
        end
    end

endmodule

// ===== hw/rtl/rcb_run_ctl.sv =====
// rcb_run_ctl: run-control latches and the per-instruction pause decision
// depends on rcb_pkg; takes the enabled-hit flag from rcb_bp_table
module rcb_run_ctl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 valid,
    input  rcb_pkg::rcb_req_t    req,
    input  rcb_pkg::rcb_lookup_t lookup,
    output logic                 pause_cpu,
    output rcb_pkg::rcb_mode_t   run_mode
);
    import rcb_pkg::*;

    logic        paused_reg,   paused_next;
    logic        step_reg,     step_next;
    logic        rtr_reg,      rtr_next;
    logic        pan_reg,      pan_next;
    logic        oneshot_reg,  oneshot_next;
    logic [15:0] os_addr_reg,  os_addr_next;

    always_comb
    begin
        paused_next  = paused_reg;
        step_next    = step_reg;
        rtr_next     = rtr_reg;
        pan_next     = pan_reg;
        oneshot_next = oneshot_reg;
        os_addr_next = os_addr_reg;
        pause_cpu    = 1'b0;

        if (valid)
        begin
            case (req.operation)
                OP_CHECK:
                begin
                    if (pan_reg)
                    begin
                        pan_next    = 1'b0;
                        paused_next = 1'b1;
                        pause_cpu   = 1'b1;
                    end
                    else if (step_reg)
                    begin
                        step_next = 1'b0;
                    end
                    else if (rtr_reg && req.opcode == RTS_OPCODE)
                    begin
                        // let the return execute, hold on the one after it
                        rtr_next = 1'b0;
                        pan_next = 1'b1;
                    end
                    else if (oneshot_reg && os_addr_reg == req.address)
                    begin
                        oneshot_next = 1'b0;
                        paused_next  = 1'b1;
                        pause_cpu    = 1'b1;
                    end
                    else if (lookup.active)
                    begin
                        paused_next = 1'b1;
                        pause_cpu   = 1'b1;
                    end
                    else
                    begin
                        pause_cpu = paused_reg;
                    end
                end
                OP_TOGGLE_PAUSE:
                begin
                    paused_next = !paused_reg;
                    if (paused_reg)
                    begin
                        step_next = 1'b0;
                    end
                end
                OP_RESUME:
                begin
                    paused_next = 1'b0;
                end
                OP_STEP:
                begin
                    rtr_next     = 1'b0;
                    pan_next     = 1'b0;
                    oneshot_next = 1'b0;
                    step_next    = 1'b1;
                    paused_next  = 1'b1;
                end
                OP_STEP_OVER:
                begin
                    os_addr_next = req.address;
                    oneshot_next = 1'b1;
                    paused_next  = 1'b0;
                end
                OP_RUN_FREE, OP_RUN_TO_RET:
                begin
                    rtr_next    = (req.operation == OP_RUN_TO_RET);
                    pan_next    = 1'b0;
                    step_next   = 1'b0;
                    paused_next = 1'b0;
                end
                OP_PAUSE:
                begin
                    rtr_next    = 1'b0;
                    pan_next    = 1'b0;
                    step_next   = 1'b0;
                    paused_next = 1'b1;
                end
                default:
                begin
                end
            endcase
        end

        if (rtr_next)
        begin
            run_mode = MODE_RTR;
        end
        else if (paused_next)
        begin
            run_mode = MODE_STEP;
        end
        else
        begin
            run_mode = MODE_FREE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            paused_reg  <= 1'b0;
            step_reg    <= 1'b0;
            rtr_reg     <= 1'b0;
            pan_reg     <= 1'b0;
            oneshot_reg <= 1'b0;
            os_addr_reg <= '0;
        end
        else
        begin
            paused_reg  <= paused_next;
            step_reg    <= step_next;
            rtr_reg     <= rtr_next;
            pan_reg     <= pan_next;
            oneshot_reg <= oneshot_next;
            os_addr_reg <= os_addr_next;
        end
    end

endmodule

// ===== hw/rtl/cpu_run_control_breakpoints_top.sv =====
// cpu_run_control_breakpoints_top: debug run-control unit with breakpoint table
// input register, rcb_run_ctl and rcb_bp_table, result register
// depends on rcb_pkg, rcb_run_ctl, rcb_bp_table
//
// usage:
//   request channel: an item is taken at a rising edge with start high and
//   busy low. busy is never raised, so one item can enter every cycle.
//   result channel: done pulses for one cycle with result valid; every item
//   gives exactly one result, in order. the receiver cannot stall, so no
//   backpressure exists and nothing is buffered beyond the result register.
//   path: the input register holds the accepted item, the result register its result.
//   throughput: 1 item per cycle; the run latches and the slot table are
//   written at the same edge as the result, so the next item in the input
//   register always sees the updated state. the check decision compares the
//   address against all slots in parallel.
//   reset: rst_n low clears the run latches, the one-shot, all slot used and
//   enabled bits, and drops any item in flight.
module cpu_run_control_breakpoints_top #(
    parameter int BREAKPOINT_SLOTS = rcb_pkg::BP_SLOTS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  rcb_pkg::rcb_req_t    request,
    output logic                 done,
    output rcb_pkg::rcb_result_t result
);
    import rcb_pkg::*;

    logic        req_valid_reg;
    rcb_req_t    req_reg;
    logic        done_reg;
    rcb_result_t result_reg;
    rcb_result_t result_next;

    rcb_lookup_t lookup;
    logic        pause_cpu;
    rcb_mode_t   run_mode;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            req_valid_reg <= start && !busy;
            done_reg      <= req_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            req_reg <= request;
        end
        result_reg <= result_next;
    end

    rcb_bp_table #(
        .SLOTS (BREAKPOINT_SLOTS)
    ) u_table (
        .clk    (clk),
        .rst_n  (rst_n),
        .valid  (req_valid_reg),
        .req    (req_reg),
        .lookup (lookup)
    );

    rcb_run_ctl u_run_ctl (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid     (req_valid_reg),
        .req       (req_reg),
        .lookup    (lookup),
        .pause_cpu (pause_cpu),
        .run_mode  (run_mode)
    );

    always_comb
    begin
        result_next.pause_cpu         = pause_cpu;
        result_next.breakpoint_active = (req_reg.operation == OP_QUERY_BP) && lookup.active;
        result_next.run_mode          = run_mode;
        result_next.table_full        = lookup.full;
    end

    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTH
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##1 done)
        else $error("accepted item gave no result two cycles later");

    a_pause_only_check: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.pause_cpu) |-> ($past(req_reg.operation) == OP_CHECK))
        else $error("pause_cpu raised for a non-check item");

    a_full_only_insert: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.table_full) |->
            ($past(req_reg.operation) == OP_ADD_BP
             || $past(req_reg.operation) == OP_TOGGLE_BP))
        else $error("table_full raised for an item that cannot insert");

    a_active_only_query: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.breakpoint_active) |-> ($past(req_reg.operation) == OP_QUERY_BP))
        else $error("breakpoint_active raised for a non-query item");
`endif

endmodule

// ===== sim/run_control_checker.sv =====
// run_control_checker: predicts and checks every result of the run-control block
// watches the request and result channels, keeps its own latches and slot table
// depends on rcb_pkg
module run_control_checker #(
    parameter int SLOTS = rcb_pkg::BP_SLOTS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  rcb_pkg::rcb_req_t    request,
    input  logic                 done,
    input  rcb_pkg::rcb_result_t result,
    output int                   errors,
    output int                   outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import rcb_pkg::*;

    logic              paused;
    logic              step_pend;
    logic              run_to_ret;
    logic              pause_next;
    logic              oneshot_armed;
    logic [15:0]       oneshot_addr;
    logic [SLOTS-1:0]  slot_used;
    logic [SLOTS-1:0]  slot_en;
    logic [15:0]       slot_addr [SLOTS];

    rcb_result_t       expected_results [$];
    int                results_seen;

    function automatic int find_slot(logic [15:0] a);
        for (int i = 0; i < SLOTS; i++)
            if (slot_used[i] && slot_addr[i] == a)
                return i;
        return -1;
    endfunction

    // lowest free slot gets the new breakpoint, enabled
    function automatic logic insert_slot(logic [15:0] a);
        for (int i = 0; i < SLOTS; i++)
        begin
            if (!slot_used[i])
            begin
                slot_used[i] = 1'b1;
                slot_addr[i] = a;
                slot_en[i]   = 1'b1;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic void free_slot(int s);
        slot_used[s] = 1'b0;
        slot_addr[s] = '0;
        slot_en[s]   = 1'b0;
    endfunction

    function automatic void clear_table();
        slot_used = '0;
        slot_en   = '0;
        for (int i = 0; i < SLOTS; i++)
            slot_addr[i] = '0;
    endfunction

    function automatic rcb_result_t predict_run_control(rcb_req_t rq);
        rcb_result_t r;
        int          s;
        r = '0;
        case (rq.operation)
            OP_CHECK:
            begin
                // priority: pause-next, step, return opcode, one-shot, table, paused
                if (pause_next)
                begin
                    pause_next  = 1'b0;
                    paused      = 1'b1;
                    r.pause_cpu = 1'b1;
                end
                else if (step_pend)
                    step_pend = 1'b0;
                else if (run_to_ret && rq.opcode == RTS_OPCODE)
                begin
                    run_to_ret = 1'b0;
                    pause_next = 1'b1;
                end
                else if (oneshot_armed && oneshot_addr == rq.address)
                begin
                    oneshot_armed = 1'b0;
                    paused        = 1'b1;
                    r.pause_cpu   = 1'b1;
                end
                else
                begin
                    s = find_slot(rq.address);
                    if (s >= 0 && slot_en[s])
                    begin
                        paused      = 1'b1;
                        r.pause_cpu = 1'b1;
                    end
                    else
                        r.pause_cpu = paused;
                end
            end
            OP_TOGGLE_PAUSE:
            begin
                if (paused)
                    step_pend = 1'b0;
                paused = !paused;
            end
            OP_RESUME:
                paused = 1'b0;
            OP_STEP:
            begin
                run_to_ret    = 1'b0;
                pause_next    = 1'b0;
                oneshot_armed = 1'b0;
                step_pend     = 1'b1;
                paused        = 1'b1;
            end
            OP_STEP_OVER:
            begin
                oneshot_addr  = rq.address;
                oneshot_armed = 1'b1;
                paused        = 1'b0;
            end
            OP_RUN_FREE, OP_RUN_TO_RET:
            begin
                run_to_ret = (rq.operation == OP_RUN_TO_RET);
                pause_next = 1'b0;
                step_pend  = 1'b0;
                paused     = 1'b0;
            end
            OP_PAUSE:
            begin
                run_to_ret = 1'b0;
                pause_next = 1'b0;
                step_pend  = 1'b0;
                paused     = 1'b1;
            end
            OP_TOGGLE_BP:
            begin
                s = find_slot(rq.address);
                if (s >= 0)
                    free_slot(s);
                else
                    r.table_full = !insert_slot(rq.address);
            end
            OP_ADD_BP:
            begin
                if (find_slot(rq.address) < 0)
                    r.table_full = !insert_slot(rq.address);
            end
            OP_REMOVE_BP:
            begin
                s = find_slot(rq.address);
                if (s >= 0)
                    free_slot(s);
            end
            OP_ENABLE_BP:
            begin
                s = find_slot(rq.address);
                if (s >= 0)
                    slot_en[s] = rq.enable;
            end
            OP_CLEAR_BPS:
                clear_table();
            OP_QUERY_BP:
            begin
                s = find_slot(rq.address);
                r.breakpoint_active = (s >= 0) && slot_en[s];
            end
            default:
            begin
            end
        endcase
        r.run_mode = run_to_ret ? MODE_RTR : (paused ? MODE_STEP : MODE_FREE);
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [1:0] got, logic [1:0] want);
        $display("mismatch at result %0d: %s got %b expected %b",
                 results_seen, field, got, want);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rcb_result_t want;
        if (!rst_n)
        begin
            paused        = 1'b0;
            step_pend     = 1'b0;
            run_to_ret    = 1'b0;
            pause_next    = 1'b0;
            oneshot_armed = 1'b0;
            oneshot_addr  = '0;
            clear_table();
            expected_results.delete();
            outstanding   = 0;
        end
        else
        begin
            if (start === 1'b1 && busy === 1'b0)
                expected_results.insert(expected_results.size(),
                                        predict_run_control(request));
            if (done === 1'b1)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("unexpected result %0d with nothing pending", results_seen);
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result.pause_cpu !== want.pause_cpu)
                        report_mismatch("pause_cpu", 2'(result.pause_cpu),
                                        2'(want.pause_cpu));
                    if (result.breakpoint_active !== want.breakpoint_active)
                        report_mismatch("breakpoint_active", 2'(result.breakpoint_active),
                                        2'(want.breakpoint_active));
                    if (result.run_mode !== want.run_mode)
                        report_mismatch("run_mode", result.run_mode, want.run_mode);
                    if (result.table_full !== want.table_full)
                        report_mismatch("table_full", 2'(result.table_full),
                                        2'(want.table_full));
                end
                results_seen++;
            end
            outstanding = expected_results.size();
        end
    end

endmodule

// ===== sim/testbench.sv =====
// testbench: stimulus and verdict for cpu_run_control_breakpoints_top
// directed run-control and breakpoint items, then random sequences with idle gaps
// depends on rcb_pkg, the block and run_control_checker
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import rcb_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 1750;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic        busy;
    rcb_req_t    request;
    logic        done;
    rcb_result_t result;
    int          errors;
    int          outstanding;
    int          cycle_count = 0;
    int          items_sent;
    logic        no_idle;
    logic [15:0] addr_pool [24];

    always #6 clk = ~clk;

    cpu_run_control_breakpoints_top DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    run_control_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .request     (request),
        .done        (done),
        .result      (result),
        .errors      (errors),
        .outstanding (outstanding)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic rcb_req_t mk(logic [3:0] op, logic [15:0] a, logic [7:0] oc, logic en);
        rcb_req_t rq;
        rq.operation = op;
        rq.address   = a;
        rq.opcode    = oc;
        rq.enable    = en;
        return rq;
    endfunction

    // mostly back to back, some short gaps, a few long ones; idle-free stretches
    function automatic int next_gap();
        int r;
        if ($urandom_range(0, 79) == 0)
            no_idle = !no_idle;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] pool_addr();
        return addr_pool[$urandom_range(0, 23)];
    endfunction

    function automatic logic [7:0] rand_opcode();
        return ($urandom_range(0, 3) == 0) ? RTS_OPCODE : 8'($urandom);
    endfunction

    function automatic rcb_req_t random_item();
        int          r;
        logic [15:0] a;
        r = $urandom_range(0, 99);
        a = ($urandom_range(0, 9) < 7) ? pool_addr() : 16'($urandom);
        if (r < 40)
            return mk(OP_CHECK, a, rand_opcode(), 1'($urandom));
        if (r < 65)
            return mk(4'($urandom_range(OP_TOGGLE_PAUSE, OP_PAUSE)), a, 8'($urandom),
                      1'($urandom));
        if (r < 95)
            return mk(4'($urandom_range(OP_TOGGLE_BP, OP_QUERY_BP)),
                      ($urandom_range(0, 9) < 8) ? pool_addr() : a,
                      8'($urandom), 1'($urandom));
        // any code, unused ones included
        return mk(4'($urandom), 16'($urandom), 8'($urandom), 1'($urandom));
    endfunction

    task automatic send_item(rcb_req_t rq);
        int gap;
        start   <= 1'b1;
        request <= rq;
        do
            @(posedge clk);
        while (busy);
        items_sent++;
        gap = next_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    initial
    begin
        rcb_req_t    directed [$];
        logic [15:0] a;
        int          pick;
        int          n;

        rst_n   <= 1'b0;
        start   <= 1'b0;
        request <= '0;
        no_idle = 1'b0;
        items_sent  = 0;
        addr_pool[0] = 16'h0000;
        addr_pool[1] = 16'hFFFF;
        for (int i = 2; i < 24; i++)
            addr_pool[i] = 16'($urandom);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed = '{
            mk(OP_QUERY_BP,     16'h0000, 8'h00, 1'b0),
            mk(OP_CHECK,        16'h0000, 8'h00, 1'b0),
            mk(OP_ADD_BP,       16'hFFFF, 8'h00, 1'b0),
            mk(OP_ADD_BP,       16'hFFFF, 8'h00, 1'b0),   // already present
            mk(OP_CHECK,        16'hFFFF, 8'hFF, 1'b1),   // breakpoint hit
            mk(OP_CHECK,        16'h1234, 8'h00, 1'b0),   // stays paused
            mk(OP_RESUME,       16'h0000, 8'h00, 1'b0),
            mk(OP_ENABLE_BP,    16'hFFFF, 8'h00, 1'b0),
            mk(OP_QUERY_BP,     16'hFFFF, 8'h00, 1'b0),
            mk(OP_CHECK,        16'hFFFF, 8'h00, 1'b0),   // disabled breakpoint
            mk(OP_TOGGLE_BP,    16'hFFFF, 8'h00, 1'b0),   // toggle off
            mk(OP_TOGGLE_BP,    16'h0000, 8'h00, 1'b0),   // toggle on
            mk(OP_QUERY_BP,     16'h0000, 8'h00, 1'b0),
            mk(OP_REMOVE_BP,    16'h0000, 8'h00, 1'b0),
            mk(OP_REMOVE_BP,    16'h0000, 8'h00, 1'b0),   // absent
            mk(OP_ENABLE_BP,    16'h0000, 8'h00, 1'b1),   // absent
            mk(OP_STEP,         16'h0000, 8'h00, 1'b0),
            mk(OP_CHECK,        16'h0100, 8'h00, 1'b0),   // single step runs one
            mk(OP_CHECK,        16'h0101, 8'h00, 1'b0),
            mk(OP_STEP_OVER,    16'h8000, 8'h00, 1'b0),
            mk(OP_CHECK,        16'h8000, 8'h00, 1'b0),   // one-shot hit
            mk(OP_RUN_TO_RET,   16'h0000, 8'h00, 1'b0),
            mk(OP_CHECK,        16'h2000, RTS_OPCODE, 1'b0),
            mk(OP_CHECK,        16'h2001, 8'h00, 1'b0),   // pause after return
            mk(OP_TOGGLE_PAUSE, 16'h0000, 8'h00, 1'b0),
            mk(OP_TOGGLE_PAUSE, 16'h0000, 8'h00, 1'b0),
            mk(OP_PAUSE,        16'h0000, 8'h00, 1'b0),
            mk(4'd14,           16'hFFFF, 8'hFF, 1'b1),   // unused codes
            mk(4'd15,           16'hFFFF, 8'hFF, 1'b1),
            mk(OP_RUN_FREE,     16'h0000, 8'h00, 1'b0),
            mk(OP_CLEAR_BPS,    16'h0000, 8'h00, 1'b0)
        };
        foreach (directed[i])
            send_item(directed[i]);

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 4)
            begin
                // fill the table, then push past it
                send_item(mk(OP_CLEAR_BPS, 16'($urandom), 8'($urandom), 1'($urandom)));
                for (int i = 0; i < BP_SLOTS; i++)
                    send_item(mk(OP_ADD_BP, addr_pool[i], 8'($urandom), 1'($urandom)));
                send_item(mk(OP_ADD_BP, 16'($urandom), 8'($urandom), 1'($urandom)));
                send_item(mk(OP_TOGGLE_BP, 16'($urandom), 8'($urandom), 1'($urandom)));
                send_item(mk(OP_RESUME, 16'h0000, 8'h00, 1'b0));
                n = $urandom_range(1, 6);
                repeat (n)
                    send_item(mk(OP_CHECK, pool_addr(), 8'($urandom), 1'($urandom)));
            end
            else if (pick < 10)
            begin
                a = pool_addr();
                send_item(mk(OP_STEP_OVER, a, 8'($urandom), 1'($urandom)));
                n = $urandom_range(0, 5);
                repeat (n)
                    send_item(mk(OP_CHECK, 16'($urandom), 8'($urandom), 1'($urandom)));
                send_item(mk(OP_CHECK, a, 8'($urandom), 1'($urandom)));
            end
            else if (pick < 16)
            begin
                send_item(mk(OP_RUN_TO_RET, 16'($urandom), 8'($urandom), 1'($urandom)));
                n = $urandom_range(0, 4);
                repeat (n)
                    send_item(mk(OP_CHECK, pool_addr(), 8'($urandom), 1'($urandom)));
                send_item(mk(OP_CHECK, 16'($urandom), RTS_OPCODE, 1'($urandom)));
                send_item(mk(OP_CHECK, 16'($urandom), 8'($urandom), 1'($urandom)));
            end
            else
                send_item(random_item());
        end
        start <= 1'b0;

        while (outstanding != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
